>>> rtl/rsi_pkg.sv
package rsi_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int NUM_FIELDS     = 8;
endpackage

>>> rtl/ray_segment_intersect.sv
// Stages from input to output: six arithmetic stages, COORD_BITS + 2 divider
// stages, one output register. Throughput: one item per cycle unless stalled;
// each quotient bit has its own compare and subtract stage, so the divider
// pipeline sets the latency, not the rate.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
module ray_segment_intersect #(
    parameter int COORD_BITS = rsi_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_seg_ax,
    input  logic signed [COORD_BITS-1:0] i_seg_ay,
    input  logic signed [COORD_BITS-1:0] i_seg_bx,
    input  logic signed [COORD_BITS-1:0] i_seg_by,
    input  logic signed [COORD_BITS-1:0] i_ray_cx,
    input  logic signed [COORD_BITS-1:0] i_ray_cy,
    input  logic signed [COORD_BITS-1:0] i_ray_ox,
    input  logic signed [COORD_BITS-1:0] i_ray_oy,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_hit_x,
    output logic signed [COORD_BITS-1:0] o_hit_y
);
    import rsi_pkg::*;

    localparam int W    = COORD_BITS;
    localparam int NW   = 3 * W + 6;
    localparam int DENW = 2 * W + 4;
    localparam int QB   = W + 1;
    localparam int CBW  = NUM_FIELDS * W;
    localparam int SBW  = CBW + 3;

    logic adv;
    logic f_v, f_negx, f_negy, f_dz;
    logic [NW-1:0] f_numx, f_numy;
    logic [DENW-1:0] f_den;
    logic [CBW-1:0] f_c, d_c;
    logic d_v, d_ovx, d_ovy, d_negx, d_negy, d_dz;
    logic [QB-1:0] d_qx, d_qy;
    logic [SBW-1:0] d_side;
    logic signed [W+1:0] qxs, qys, px, py;
    logic signed [W-1:0] ax, ay, bx, by, cx, cy, ox, oy;
    logic hit;
    logic r_ov, r_hit;
    logic signed [W-1:0] r_hx, r_hy;

    function automatic logic in_span(input logic signed [W+1:0] p,
                                     input logic signed [W-1:0] u,
                                     input logic signed [W-1:0] v);
        return ((u <= p) && (p <= v)) || ((v <= p) && (p <= u));
    endfunction

    assign adv     = !r_ov || !i_stall;
    assign o_stall = !adv;

    rsi_front #(.W(W)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (i_valid),
        .i_coords ({i_seg_ax, i_seg_ay, i_seg_bx, i_seg_by,
                    i_ray_cx, i_ray_cy, i_ray_ox, i_ray_oy}),
        .o_valid  (f_v),
        .o_numx   (f_numx),
        .o_numy   (f_numy),
        .o_den    (f_den),
        .o_negx   (f_negx),
        .o_negy   (f_negy),
        .o_dz     (f_dz),
        .o_coords (f_c)
    );

    rsi_div #(.NW(NW), .DENW(DENW), .QB(QB), .SBW(SBW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (f_v),
        .i_numx  (f_numx),
        .i_numy  (f_numy),
        .i_den   (f_den),
        .i_side  ({f_negx, f_negy, f_dz, f_c}),
        .o_valid (d_v),
        .o_qx    (d_qx),
        .o_qy    (d_qy),
        .o_ovfx  (d_ovx),
        .o_ovfy  (d_ovy),
        .o_side  (d_side)
    );

    assign {d_negx, d_negy, d_dz, d_c} = d_side;
    assign ax = $signed(d_c[8*W-1 -: W]);
    assign ay = $signed(d_c[7*W-1 -: W]);
    assign bx = $signed(d_c[6*W-1 -: W]);
    assign by = $signed(d_c[5*W-1 -: W]);
    assign cx = $signed(d_c[4*W-1 -: W]);
    assign cy = $signed(d_c[3*W-1 -: W]);
    assign ox = $signed(d_c[2*W-1 -: W]);
    assign oy = $signed(d_c[W-1 -: W]);

    assign qxs = $signed({1'b0, d_qx});
    assign qys = $signed({1'b0, d_qy});
    assign px  = d_negx ? -qxs : qxs;
    assign py  = d_negy ? -qys : qys;

    assign hit = !d_dz && !d_ovx && !d_ovy
              && in_span(px, cx, ox) && in_span(py, cy, oy)
              && in_span(px, ax, bx) && in_span(py, ay, by);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit <= hit;
            r_hx  <= hit ? px[W-1:0] : '0;
            r_hy  <= hit ? py[W-1:0] : '0;
        end
    end

    assign o_valid = r_ov;
    assign o_hit   = r_hit;
    assign o_hit_x = r_hx;
    assign o_hit_y = r_hy;
endmodule

>>> rtl/rsi_front.sv
module rsi_front #(
    parameter int W = rsi_pkg::COORD_BITS_DEF,
    localparam int NW = 3 * W + 6,
    localparam int DENW = 2 * W + 4,
    localparam int CBW = rsi_pkg::NUM_FIELDS * W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [CBW-1:0]        i_coords,
    output logic                  o_valid,
    output logic [NW-1:0]         o_numx,
    output logic [NW-1:0]         o_numy,
    output logic [DENW-1:0]       o_den,
    output logic                  o_negx,
    output logic                  o_negy,
    output logic                  o_dz,
    output logic [CBW-1:0]        o_coords
);
    import rsi_pkg::*;

    localparam int DNW = 2 * W + 3;

    logic signed [W-1:0] ax, ay, bx, by, cx, cy, ox, oy;
    logic signed [W-1:0] ax3, ay3;
    logic [6:1] r_v;
    logic [CBW-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic signed [W:0] r_dx1, r_dy1, r_rx1, r_ry1, r_acx1, r_acy1;
    logic signed [W:0] r_dx2, r_dy2, r_dx3, r_dy3;
    logic signed [2*W+1:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [DNW-1:0] r_d3, r_n3, r_d4, r_d5;
    logic signed [NW-1:0] r_m1x, r_m2x, r_m1y, r_m2y, r_numx5, r_numy5;
    logic [NW-1:0] r_numx6, r_numy6;
    logic [DENW-1:0] r_den6;
    logic r_negx6, r_negy6, r_dz6;
    logic [DNW-1:0] absd;

    assign ax = $signed(i_coords[8*W-1 -: W]);
    assign ay = $signed(i_coords[7*W-1 -: W]);
    assign bx = $signed(i_coords[6*W-1 -: W]);
    assign by = $signed(i_coords[5*W-1 -: W]);
    assign cx = $signed(i_coords[4*W-1 -: W]);
    assign cy = $signed(i_coords[3*W-1 -: W]);
    assign ox = $signed(i_coords[2*W-1 -: W]);
    assign oy = $signed(i_coords[W-1 -: W]);
    assign ax3 = $signed(r_c3[8*W-1 -: W]);
    assign ay3 = $signed(r_c3[7*W-1 -: W]);
    assign absd = r_d5[DNW-1] ? DNW'(-r_d5) : DNW'(r_d5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1   <= i_coords;
            r_dx1  <= (W+1)'(bx) - (W+1)'(ax);
            r_dy1  <= (W+1)'(by) - (W+1)'(ay);
            r_rx1  <= (W+1)'(ox) - (W+1)'(cx);
            r_ry1  <= (W+1)'(oy) - (W+1)'(cy);
            r_acx1 <= (W+1)'(ax) - (W+1)'(cx);
            r_acy1 <= (W+1)'(ay) - (W+1)'(cy);

            r_c2  <= r_c1;
            r_dx2 <= r_dx1;
            r_dy2 <= r_dy1;
            r_p1  <= r_ry1 * r_dx1;
            r_p2  <= r_rx1 * r_dy1;
            r_p3  <= r_rx1 * r_acy1;
            r_p4  <= r_ry1 * r_acx1;

            r_c3  <= r_c2;
            r_dx3 <= r_dx2;
            r_dy3 <= r_dy2;
            r_d3  <= DNW'(r_p1) - DNW'(r_p2);
            r_n3  <= DNW'(r_p3) - DNW'(r_p4);

            r_c4  <= r_c3;
            r_d4  <= r_d3;
            r_m1x <= r_d3 * $signed({ax3, 1'b1});
            r_m1y <= r_d3 * $signed({ay3, 1'b1});
            r_m2x <= $signed({r_n3, 1'b0}) * r_dx3;
            r_m2y <= $signed({r_n3, 1'b0}) * r_dy3;

            r_c5    <= r_c4;
            r_d5    <= r_d4;
            r_numx5 <= r_m1x + r_m2x;
            r_numy5 <= r_m1y + r_m2y;

            r_c6    <= r_c5;
            r_numx6 <= r_numx5[NW-1] ? NW'(-r_numx5) : NW'(r_numx5);
            r_numy6 <= r_numy5[NW-1] ? NW'(-r_numy5) : NW'(r_numy5);
            r_negx6 <= r_numx5[NW-1] ^ r_d5[DNW-1];
            r_negy6 <= r_numy5[NW-1] ^ r_d5[DNW-1];
            r_den6  <= {absd, 1'b0};
            r_dz6   <= (r_d5 == '0);
        end
    end

    assign o_valid  = r_v[6];
    assign o_numx   = r_numx6;
    assign o_numy   = r_numy6;
    assign o_den    = r_den6;
    assign o_negx   = r_negx6;
    assign o_negy   = r_negy6;
    assign o_dz     = r_dz6;
    assign o_coords = r_c6;
endmodule

>>> rtl/rsi_div.sv
module rsi_div #(
    parameter int NW = 3 * rsi_pkg::COORD_BITS_DEF + 6,
    parameter int DENW = 2 * rsi_pkg::COORD_BITS_DEF + 4,
    parameter int QB = rsi_pkg::COORD_BITS_DEF + 1,
    parameter int SBW = rsi_pkg::NUM_FIELDS * rsi_pkg::COORD_BITS_DEF + 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NW-1:0]    i_numx,
    input  logic [NW-1:0]    i_numy,
    input  logic [DENW-1:0]  i_den,
    input  logic [SBW-1:0]   i_side,
    output logic             o_valid,
    output logic [QB-1:0]    o_qx,
    output logic [QB-1:0]    o_qy,
    output logic             o_ovfx,
    output logic             o_ovfy,
    output logic [SBW-1:0]   o_side
);
    localparam int CW = NW + 1;

    logic             r_v    [1:QB+1];
    logic [NW-1:0]    r_rx   [1:QB+1];
    logic [NW-1:0]    r_ry   [1:QB+1];
    logic [QB-1:0]    r_qx   [1:QB+1];
    logic [QB-1:0]    r_qy   [1:QB+1];
    logic             r_ovx  [1:QB+1];
    logic             r_ovy  [1:QB+1];
    logic [DENW-1:0]  r_den  [1:QB+1];
    logic [SBW-1:0]   r_side [1:QB+1];

    for (genvar s = 0; s <= QB; s++) begin : g_st
        localparam int SH = QB - s;
        logic            c_v, c_ovx, c_ovy, gex, gey;
        logic [NW-1:0]   c_rx, c_ry;
        logic [QB-1:0]   c_qx, c_qy;
        logic [DENW-1:0] c_den;
        logic [SBW-1:0]  c_side;
        logic [CW-1:0]   dsh, subx, suby;

        if (s == 0) begin : g_in
            assign c_v    = i_valid;
            assign c_rx   = i_numx;
            assign c_ry   = i_numy;
            assign c_qx   = '0;
            assign c_qy   = '0;
            assign c_ovx  = 1'b0;
            assign c_ovy  = 1'b0;
            assign c_den  = i_den;
            assign c_side = i_side;
        end else begin : g_mid
            assign c_v    = r_v[s];
            assign c_rx   = r_rx[s];
            assign c_ry   = r_ry[s];
            assign c_qx   = r_qx[s];
            assign c_qy   = r_qy[s];
            assign c_ovx  = r_ovx[s];
            assign c_ovy  = r_ovy[s];
            assign c_den  = r_den[s];
            assign c_side = r_side[s];
        end

        assign dsh  = CW'(c_den) << SH;
        assign subx = {1'b0, c_rx} - dsh;
        assign suby = {1'b0, c_ry} - dsh;
        assign gex  = !subx[CW-1];
        assign gey  = !suby[CW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1]  <= c_den;
                r_side[s+1] <= c_side;
                if (s == 0) begin
                    r_rx[s+1]  <= c_rx;
                    r_ry[s+1]  <= c_ry;
                    r_qx[s+1]  <= c_qx;
                    r_qy[s+1]  <= c_qy;
                    r_ovx[s+1] <= gex;
                    r_ovy[s+1] <= gey;
                end else begin
                    r_rx[s+1]  <= gex ? subx[NW-1:0] : c_rx;
                    r_ry[s+1]  <= gey ? suby[NW-1:0] : c_ry;
                    r_qx[s+1]  <= {c_qx[QB-2:0], gex};
                    r_qy[s+1]  <= {c_qy[QB-2:0], gey};
                    r_ovx[s+1] <= c_ovx;
                    r_ovy[s+1] <= c_ovy;
                end
            end
        end
    end

    assign o_valid = r_v[QB+1];
    assign o_qx    = r_qx[QB+1];
    assign o_qy    = r_qy[QB+1];
    assign o_ovfx  = r_ovx[QB+1];
    assign o_ovfy  = r_ovy[QB+1];
    assign o_side  = r_side[QB+1];
endmodule

>>> sim/rsi_checker.sv
module rsi_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_bx,
    input  logic signed [15:0] i_by,
    input  logic signed [15:0] i_cx,
    input  logic signed [15:0] i_cy,
    input  logic signed [15:0] i_ox,
    input  logic signed [15:0] i_oy,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic               i_hit,
    input  logic signed [15:0] i_hit_x,
    input  logic signed [15:0] i_hit_y,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              hit;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_crossing;

    t_crossing crossings_due[$];

    function automatic longint quotient_toward_zero(longint num, longint den);
        longint q;
        q = num / den;
        if (q > 64'sd1099511627776) q = 64'sd1099511627776;
        if (q < -64'sd1099511627776) q = -64'sd1099511627776;
        return q;
    endfunction

    function automatic logic between(longint p, longint u, longint v);
        return (u <= p && p <= v) || (v <= p && p <= u);
    endfunction

    function automatic t_crossing predict_crossing(
        longint ax, longint ay, longint bx, longint by,
        longint cx, longint cy, longint ox, longint oy);
        t_crossing r;
        longint dx, dy, rx, ry, den, num, px, py;
        dx = bx - ax;
        dy = by - ay;
        rx = ox - cx;
        ry = oy - cy;
        den = ry * dx - rx * dy;
        r = '0;
        if (den != 0) begin
            num = rx * (ay - cy) - ry * (ax - cx);
            px = quotient_toward_zero(den * (2 * ax + 1) + 2 * num * dx, 2 * den);
            py = quotient_toward_zero(den * (2 * ay + 1) + 2 * num * dy, 2 * den);
            if (between(px, cx, ox) && between(py, cy, oy) &&
                between(px, ax, bx) && between(py, ay, by)) begin
                r.hit = 1'b1;
                r.x = px[15:0];
                r.y = py[15:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = crossings_due.size();

    always @(posedge i_clk) begin
        t_crossing e;
        if (i_rst_n && i_valid && !i_stall_in)
            crossings_due.push_back(predict_crossing(i_ax, i_ay, i_bx, i_by,
                                                      i_cx, i_cy, i_ox, i_oy));
        if (i_rst_n && i_res_valid && !i_res_stall) begin
            if (crossings_due.size() == 0) begin
                report_mismatch("item with nothing expected");
            end else begin
                e = crossings_due.pop_front();
                if (i_hit !== e.hit)
                    report_mismatch($sformatf("hit %b want %b", i_hit, e.hit));
                if (i_hit_x !== e.x)
                    report_mismatch($sformatf("hit_x %0d want %0d", i_hit_x, e.x));
                if (i_hit_y !== e.y)
                    report_mismatch($sformatf("hit_y %0d want %0d", i_hit_y, e.y));
            end
        end
    end
endmodule

>>> sim/tb_ray_segment_intersect.sv
module tb_ray_segment_intersect;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 5000;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall, o_hit;
    logic signed [15:0] i_seg_ax, i_seg_ay, i_seg_bx, i_seg_by;
    logic signed [15:0] i_ray_cx, i_ray_cy, i_ray_ox, i_ray_oy;
    logic signed [15:0] o_hit_x, o_hit_y;
    int errors, pending, quiet;

    ray_segment_intersect u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_seg_ax(i_seg_ax), .i_seg_ay(i_seg_ay), .i_seg_bx(i_seg_bx),
        .i_seg_by(i_seg_by), .i_ray_cx(i_ray_cx), .i_ray_cy(i_ray_cy),
        .i_ray_ox(i_ray_ox), .i_ray_oy(i_ray_oy), .o_valid(o_valid),
        .i_stall(i_stall), .o_hit(o_hit), .o_hit_x(o_hit_x), .o_hit_y(o_hit_y)
    );

    rsi_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_ax(i_seg_ax), .i_ay(i_seg_ay), .i_bx(i_seg_bx), .i_by(i_seg_by),
        .i_cx(i_ray_cx), .i_cy(i_ray_cy), .i_ox(i_ray_ox), .i_oy(i_ray_oy),
        .i_res_valid(o_valid), .i_res_stall(i_stall), .i_hit(o_hit),
        .i_hit_x(o_hit_x), .i_hit_y(o_hit_y), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [15:0] pick_coord(int spread);
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    task automatic send_pair(logic signed [15:0] ax, ay, bx, by, cx, cy, ox, oy);
        int gap;
        gap = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 14));
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_seg_ax <= ax; i_seg_ay <= ay; i_seg_bx <= bx; i_seg_by <= by;
        i_ray_cx <= cx; i_ray_cy <= cy; i_ray_ox <= ox; i_ray_oy <= oy;
        do @(posedge i_clk); while (o_stall);
    endtask

    // random segment and ray near a chosen point: pick the point, spread endpoints around it
    task automatic send_crossing(int spread);
        int px, py;
        px = $signed($urandom_range(0, 2 * spread)) - spread;
        py = $signed($urandom_range(0, 2 * spread)) - spread;
        send_pair(16'(px - $urandom_range(0, 200)),
                  16'(py + $signed($urandom_range(0, 400)) - 200),
                  16'(px + $urandom_range(0, 200)),
                  16'(py + $signed($urandom_range(0, 400)) - 200),
                  16'(px + $signed($urandom_range(0, 400)) - 200),
                  16'(py - $urandom_range(0, 200)),
                  16'(px + $signed($urandom_range(0, 400)) - 200),
                  16'(py + $urandom_range(0, 200)));
    endtask

    initial begin
        int hold;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            hold = int'($urandom_range(0, 14));
            if ($urandom_range(0, 3) == 0) hold = 0;
            if (hold == 0) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    initial begin
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG) begin
                $display("ray_segment_intersect regression: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        {i_seg_ax, i_seg_ay, i_seg_bx, i_seg_by} = '0;
        {i_ray_cx, i_ray_cy, i_ray_ox, i_ray_oy} = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pair(-10, 0, 10, 0, 0, -10, 0, 10);
        send_pair(-10, 0, 10, 0, 0, 5, 0, 10);
        send_pair(0, 0, 10, 0, 0, 5, 10, 5);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(-3, -3, -3, -3, -3, -3, -3, -3);
        send_pair(-5, 0, -5, 10, -10, 5, 0, 5);
        send_pair(0, 0, 5, 0, -5, -5, 5, 5);
        send_pair(0, 0, 3, 0, 0, 0, 3, 3);
        send_pair(-5, -2, 0, -3, -3, -5, -2, 0);
        send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                  16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_pair(16'sh8000, 0, 16'sh7fff, 0, 0, 16'sh8000, 0, 16'sh7fff);
        send_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_pair(16'shffff, 16'shffff, 16'shffff, 16'shffff,
                  16'shffff, 16'shffff, 16'shffff, 16'shffff);
        send_pair(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
                  16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh5555);
        send_pair(1, 1, 2, 2, 3, 3, 4, 4);

        repeat (1900) begin
            case ($urandom_range(0, 9))
                0, 1: send_pair(pick_coord(32768), pick_coord(32768), pick_coord(32768),
                                pick_coord(32768), pick_coord(32768), pick_coord(32768),
                                pick_coord(32768), pick_coord(32768));
                2: send_pair(pick_coord(8), pick_coord(8), pick_coord(8), pick_coord(8),
                             pick_coord(8), pick_coord(8), pick_coord(8), pick_coord(8));
                3: send_crossing(30000);
                default: send_crossing(1000);
            endcase
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) $display("ray_segment_intersect regression: pass");
        else $display("ray_segment_intersect regression: fail");
        $finish;
    end
endmodule

>>> files.f
rtl/rsi_pkg.sv
rtl/rsi_front.sv
rtl/rsi_div.sv
rtl/ray_segment_intersect.sv
sim/rsi_checker.sv
sim/tb_ray_segment_intersect.sv
